// File: src/clock_page_replacement_assert.svh
// Assertion macros for the clock page replacement block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CLOCK_PAGE_REPLACEMENT_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication
`define CPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cpr_pkg.sv
// Shared constants, types and helpers for the clock page replacement block.
// No dependencies.
package cpr_pkg;

	localparam int FRAME_COUNT = 16;
	localparam int PAGE_BITS   = 16;
	localparam int CFG_W       = 5;
	localparam int FRAME_W     = 4;
	localparam int IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int CNT_W       = $clog2(FRAME_COUNT + 1);

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [PAGE_BITS-1:0] page_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MISS,
		ST_SWEEP,
		ST_EVICT
	} cpr_state_t;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
		logic               evicted;
		page_t              evicted_page;
	} cpr_result_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		page_t wdata;
		idx_t  raddr;
	} cpr_ram_req_t;

	// frames_in_use saturated to 1..FRAME_COUNT
	function automatic cnt_t managed_count(logic [CFG_W-1:0] cfg);
		cnt_t n;
		if (cfg == '0) begin
			n = CNT_W'(1);
		end else if (int'(cfg) > FRAME_COUNT) begin
			n = CNT_W'(FRAME_COUNT);
		end else begin
			n = CNT_W'(cfg);
		end
		return n;
	endfunction

	// hand advance with wrap at n
	function automatic idx_t next_idx(idx_t h, cnt_t n);
		cnt_t nxt;
		nxt = CNT_W'(h) + CNT_W'(1);
		return (nxt >= n) ? '0 : IDX_W'(nxt);
	endfunction

endpackage

// File: src/cpr_page_if.sv
// Request channel: one page access per transfer.
// Depends on cpr_pkg.
interface cpr_page_if;
	logic                          valid;
	logic                          ready;
	logic [cpr_pkg::PAGE_BITS-1:0] page;

	modport source(output valid, output page, input ready);
	modport sink(input valid, input page, output ready);
endinterface

// File: src/cpr_result_if.sv
// Result channel: one lookup / replacement outcome per transfer.
// Depends on cpr_pkg.
interface cpr_result_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [cpr_pkg::FRAME_W-1:0]   frame;
	logic                          evicted;
	logic [cpr_pkg::PAGE_BITS-1:0] evicted_page;

	modport source(output valid, output hit, output frame, output evicted,
		output evicted_page, input ready);
	modport sink(input valid, input hit, input frame, input evicted,
		input evicted_page, output ready);
endinterface

// File: src/cpr_cfg_if.sv
// Configuration write channel for frames_in_use.
// Depends on cpr_pkg.
interface cpr_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [cpr_pkg::CFG_W-1:0] frames_in_use;

	modport source(output valid, output frames_in_use, input ready);
	modport sink(input valid, input frames_in_use, output ready);
endinterface

// File: src/clock_page_replacement.sv
// Clock (second-chance) page replacement, top level.
// Depends on cpr_pkg, the channel interfaces, cpr_ram, cpr_seq and the assert header.
//
//  channel | dir | payload                              | transfer when
//  req     | in  | page                                 | req.valid && req.ready
//  rsp     | out | hit, frame, evicted, evicted_page    | rsp.valid && rsp.ready
//  cfg     | in  | frames_in_use                        | cfg.valid && cfg.ready (ready while idle)
//
// A hit in frame k ends the scan once frame k is compared; the tag RAM is
// scanned one frame per cycle through a single read port and comparator.
// A miss compares all n managed frames, then fills the lowest empty one; an eviction
// first sweeps the hand past referenced frames (at most n), clearing their bits.
// Reset clears valid/referenced bits, the hand and sets frames_in_use to 16;
// tag RAM is not cleared. A stalled result holds the sequencer at its last step,
// while req.ready returns as soon as the result is registered.
// A pending cfg write holds off the next request.
`include "clock_page_replacement_assert.svh"

module clock_page_replacement (
	input  logic            clk,
	input  logic            arst_n,
	cpr_page_if.sink        req,
	cpr_result_if.source    rsp,
	cpr_cfg_if.sink         cfg
);

	logic [cpr_pkg::CFG_W-1:0] frames_q;
	cpr_pkg::cnt_t             n;
	logic                      start;
	logic                      idle;
	logic                      done;
	logic                      out_free;
	logic                      out_vld_q;
	cpr_pkg::cpr_result_t      res;
	cpr_pkg::cpr_result_t      res_q;
	cpr_pkg::cpr_ram_req_t     ram_req;
	cpr_pkg::page_t            ram_rdata;

	// frame count only changes between accesses; a cfg write wins over a request
	assign cfg.ready = idle;
	assign n         = cpr_pkg::managed_count(frames_q);
	assign req.ready = idle && !cfg.valid;
	assign start     = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q  <= cpr_pkg::CFG_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				frames_q <= cfg.frames_in_use;
			end
			if (done) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.hit          = res_q.hit;
	assign rsp.frame        = res_q.frame;
	assign rsp.evicted      = res_q.evicted;
	assign rsp.evicted_page = res_q.evicted_page;

	cpr_ram #(
		.WIDTH(cpr_pkg::PAGE_BITS),
		.DEPTH(cpr_pkg::FRAME_COUNT)
	) u_tags (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	cpr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.page     (req.page),
		.n        (n),
		.out_free (out_free),
		.ram_rdata(ram_rdata),
		.ram_req  (ram_req),
		.idle     (idle),
		.done     (done),
		.res      (res)
	);

	`CPR_ASSERT_NOW(a_done_has_room, done, out_free, "result finished with output register full")
	`CPR_ASSERT_NEXT(a_busy_after_req, start, !req.ready, "request taken while previous one in flight")
	`CPR_ASSERT_NOW(a_hit_no_evict, rsp.valid && rsp.hit, !rsp.evicted, "hit reported with eviction")
	`CPR_ASSERT_NOW(a_evict_page_zero, rsp.valid && !rsp.evicted, rsp.evicted_page == '0, "stale evicted page")

endmodule

// File: src/cpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/cpr_seq.sv
// Sequencer: tag search through the tag RAM, empty-frame fill and clock sweep.
// Holds valid/referenced bits and the hand. Depends on cpr_pkg.
module cpr_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cpr_pkg::page_t        page,
	input  cpr_pkg::cnt_t         n,
	input  logic                  out_free,
	input  cpr_pkg::page_t        ram_rdata,
	output cpr_pkg::cpr_ram_req_t ram_req,
	output logic                  idle,
	output logic                  done,
	output cpr_pkg::cpr_result_t  res
);

	cpr_pkg::cpr_state_t state_q, state_d;
	cpr_pkg::page_t      page_q;
	cpr_pkg::cnt_t       idx_q;
	logic                cmp_vld_q;
	cpr_pkg::idx_t       cmp_idx_q;
	cpr_pkg::idx_t       h_q;
	cpr_pkg::idx_t       hand_q;
	logic [cpr_pkg::FRAME_COUNT-1:0] valid_q;
	logic [cpr_pkg::FRAME_COUNT-1:0] ref_q;

	logic          cmp_hit;
	logic          scan_more;
	logic          empty_found;
	cpr_pkg::idx_t empty_idx;
	logic          mark_en;
	cpr_pkg::idx_t mark_idx;
	logic          clr_en;

	// shared comparator: tag read last cycle against the requested page
	assign cmp_hit   = cmp_vld_q && valid_q[cmp_idx_q] && (ram_rdata == page_q);
	assign scan_more = (idx_q < n);

	// lowest empty managed frame
	always_comb begin
		empty_found = 1'b0;
		empty_idx   = '0;
		for (int i = cpr_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
			if ((cpr_pkg::CNT_W'(i) < n) && !valid_q[i]) begin
				empty_found = 1'b1;
				empty_idx   = cpr_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cpr_pkg::ST_IDLE: begin
				if (start) state_d = cpr_pkg::ST_SEARCH;
			end
			cpr_pkg::ST_SEARCH: begin
				if (cmp_hit) begin
					if (out_free) state_d = cpr_pkg::ST_IDLE;
				end else if (!scan_more) begin
					state_d = cpr_pkg::ST_MISS;
				end
			end
			cpr_pkg::ST_MISS: begin
				if (!empty_found) begin
					state_d = cpr_pkg::ST_SWEEP;
				end else if (out_free) begin
					state_d = cpr_pkg::ST_IDLE;
				end
			end
			cpr_pkg::ST_SWEEP: begin
				if (!ref_q[h_q]) state_d = cpr_pkg::ST_EVICT;
			end
			cpr_pkg::ST_EVICT: begin
				if (out_free) state_d = cpr_pkg::ST_IDLE;
			end
			default: state_d = cpr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ram_req       = '0;
		ram_req.raddr = idx_q[cpr_pkg::IDX_W-1:0];
		ram_req.wdata = page_q;
		done          = 1'b0;
		res           = '0;
		mark_en       = 1'b0;
		mark_idx      = '0;
		clr_en        = 1'b0;
		idle          = 1'b0;
		case (state_q)
			cpr_pkg::ST_IDLE: begin
				idle = 1'b1;
			end
			cpr_pkg::ST_SEARCH: begin
				if (cmp_hit) begin
					// keep re-reading the matching tag while the result stalls
					ram_req.raddr = cmp_idx_q;
					if (out_free) begin
						done      = 1'b1;
						res.hit   = 1'b1;
						res.frame = cpr_pkg::FRAME_W'(cmp_idx_q);
						mark_en   = 1'b1;
						mark_idx  = cmp_idx_q;
					end
				end
			end
			cpr_pkg::ST_MISS: begin
				if (empty_found && out_free) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = empty_idx;
					done          = 1'b1;
					res.frame     = cpr_pkg::FRAME_W'(empty_idx);
					mark_en       = 1'b1;
					mark_idx      = empty_idx;
				end
			end
			cpr_pkg::ST_SWEEP: begin
				ram_req.raddr = h_q;
				clr_en        = ref_q[h_q];
			end
			cpr_pkg::ST_EVICT: begin
				ram_req.raddr = h_q;
				if (out_free) begin
					ram_req.we       = 1'b1;
					ram_req.waddr    = h_q;
					done             = 1'b1;
					res.frame        = cpr_pkg::FRAME_W'(h_q);
					res.evicted      = 1'b1;
					res.evicted_page = ram_rdata;
					mark_en          = 1'b1;
					mark_idx         = h_q;
				end
			end
			default: begin
				idle = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cpr_pkg::ST_IDLE;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
			hand_q    <= '0;
			valid_q   <= '0;
			ref_q     <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q     <= '0;
				cmp_vld_q <= 1'b0;
			end else if (state_q == cpr_pkg::ST_SEARCH && !cmp_hit && scan_more) begin
				idx_q     <= idx_q + cpr_pkg::CNT_W'(1);
				cmp_vld_q <= 1'b1;
			end
			if (state_q == cpr_pkg::ST_EVICT && out_free) begin
				hand_q <= cpr_pkg::next_idx(h_q, n);
			end
			if (mark_en) begin
				valid_q[mark_idx] <= 1'b1;
				ref_q[mark_idx]   <= 1'b1;
			end
			if (clr_en) begin
				ref_q[h_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			page_q <= page;
		end
		if (state_q == cpr_pkg::ST_SEARCH && !cmp_hit && scan_more) begin
			cmp_idx_q <= idx_q[cpr_pkg::IDX_W-1:0];
		end
		if (state_q == cpr_pkg::ST_MISS) begin
			// hand outside the managed frames restarts at frame 0
			h_q <= (cpr_pkg::CNT_W'(hand_q) < n) ? hand_q : '0;
		end else if (clr_en) begin
			h_q <= cpr_pkg::next_idx(h_q, n);
		end
	end

endmodule
